/* design/grsc_pkg.sv */
// ============================================================================
// grsc_pkg: shared types and constants for the gain-ranged sample codec
// Field widths, clamp codes and encode range limits.
// ============================================================================
package grsc_pkg;

    // Field widths
    localparam int CODE_W       = 16;
    localparam int SAMPLE_IN_W  = 28;
    localparam int SAMPLE_OUT_W = 27;
    localparam int GAIN_W       = 3;
    localparam int MANT_W       = 13;
    localparam int SHAMT_W      = 4;

    // Largest shift of the mantissa (gain 0)
    localparam logic [SHAMT_W-1:0] MAX_SHIFT = 4'd14;

    // Encode range limits (sample times 8)
    localparam logic signed [SAMPLE_IN_W-1:0] ENC_HIGH_LIMIT = 28'sd67108856;
    localparam logic signed [SAMPLE_IN_W-1:0] ENC_LOW_LIMIT  = -28'sd67108864;

    // Clamp codes for out-of-range encode input
    localparam logic [CODE_W-1:0] CODE_HIGH_CLAMP = 16'hefff;
    localparam logic [CODE_W-1:0] CODE_LOW_CLAMP  = 16'hffff;

    // Direction register values
    localparam logic DIR_DECODE = 1'b0;
    localparam logic DIR_ENCODE = 1'b1;

    // One result item
    typedef struct packed {
        logic signed [SAMPLE_OUT_W-1:0] sample;
        logic [CODE_W-1:0]              code;
        logic                           saturated;
    } grsc_result_t;

endpackage

/* design/gain_ranged_sample_codec.sv */
// ============================================================================
// gain_ranged_sample_codec: gain-ranged code <-> fixed-point sample converter
// Decodes a 3-bit gain / 13-bit mantissa word to a sample times 8, or encodes
// a sample times 8 into that word with clamping, chosen by one register.
// ============================================================================
//
//  Channel   Signals                                   Direction
//  --------  ----------------------------------------  ---------
//  input     in_valid, in_ready, code_in, sample_in    in
//  output    out_valid, out_ready, sample_out,         out
//            code_out, saturated
//  config    cfg_wr_en, cfg_wr_data (direction)        in
//
//  An input transfer is held in the input register, then shifts and a gain
//  priority select load it into the result register, which drives the
//  output; an output stall can hold the item in the input register between.
//  Throughput is one item per cycle while out_ready stays high; both stages
//  advance whenever the next stage is empty or being drained. An output stall holds a full result stage,
//  and once the input stage has filled behind it, the input as well.
//  Reset clears both stage valid bits and sets direction to decode.
//
module gain_ranged_sample_codec (
    input  logic                                      clk,
    input  logic                                      rst_n,
    // configuration
    input  logic                                      cfg_wr_en,
    input  logic                                      cfg_wr_data,
    // input channel
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  logic [grsc_pkg::CODE_W-1:0]               code_in,
    input  logic signed [grsc_pkg::SAMPLE_IN_W-1:0]   sample_in,
    // output channel
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output logic signed [grsc_pkg::SAMPLE_OUT_W-1:0]  sample_out,
    output logic [grsc_pkg::CODE_W-1:0]               code_out,
    output logic                                      saturated
);

    logic                                     direction_reg;
    logic                                     s1_valid_reg;
    logic [grsc_pkg::CODE_W-1:0]              s1_code_reg;
    logic signed [grsc_pkg::SAMPLE_IN_W-1:0]  s1_sample_reg;
    logic                                     s2_valid_reg;
    grsc_pkg::grsc_result_t                   s2_result_reg;
    grsc_pkg::grsc_result_t                   s2_result_next;

    logic                                     s2_load;
    logic                                     s1_load;

    // decode path
    logic [grsc_pkg::GAIN_W-1:0]              dec_gain;
    logic signed [grsc_pkg::SAMPLE_OUT_W-1:0] dec_mant;
    logic [grsc_pkg::SHAMT_W-1:0]             dec_shamt;
    logic signed [grsc_pkg::SAMPLE_OUT_W-1:0] dec_sample;

    // encode path
    logic                                     enc_high;
    logic                                     enc_low;
    logic [grsc_pkg::GAIN_W-1:0]              enc_gain;
    logic [grsc_pkg::SHAMT_W-1:0]             enc_shamt;
    logic signed [grsc_pkg::SAMPLE_IN_W-1:0]  enc_window;
    logic signed [grsc_pkg::SAMPLE_IN_W-1:0]  enc_top;
    logic [grsc_pkg::CODE_W-1:0]              enc_code;

    // Pipeline flow control
    assign s2_load  = s1_valid_reg && (!s2_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s2_load;
    assign s1_load  = in_valid && in_ready;

    // Direction register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= grsc_pkg::DIR_DECODE;
        end
        else if (cfg_wr_en)
        begin
            direction_reg <= cfg_wr_data;
        end
    end

    // Input stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // Input stage payload
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_code_reg   <= code_in;
            s1_sample_reg <= sample_in;
        end
    end

    // Decode: sign-extended mantissa shifted left by 14 - 2g
    always_comb
    begin
        dec_gain   = s1_code_reg[grsc_pkg::CODE_W-1 -: grsc_pkg::GAIN_W];
        dec_mant   = {{(grsc_pkg::SAMPLE_OUT_W-grsc_pkg::MANT_W){s1_code_reg[grsc_pkg::MANT_W-1]}},
                      s1_code_reg[grsc_pkg::MANT_W-1:0]};
        dec_shamt  = grsc_pkg::MAX_SHIFT - {dec_gain, 1'b0};
        dec_sample = dec_mant <<< dec_shamt;
    end

    // Encode: range clamp, then largest gain whose top bits are all sign copies
    always_comb
    begin
        enc_high = s1_sample_reg > grsc_pkg::ENC_HIGH_LIMIT;
        enc_low  = s1_sample_reg < grsc_pkg::ENC_LOW_LIMIT;
        enc_gain = '0;
        enc_top  = '0;
        for (int k = 1; k <= 7; k++)
        begin
            enc_top = s1_sample_reg >>> (26 - 2 * k);
            if (enc_top == '0 || enc_top == '1)
            begin
                enc_gain = grsc_pkg::GAIN_W'(k);
            end
        end
        enc_shamt  = grsc_pkg::MAX_SHIFT - {enc_gain, 1'b0};
        enc_window = s1_sample_reg >>> enc_shamt;
        if (enc_high)
        begin
            enc_code = grsc_pkg::CODE_HIGH_CLAMP;
        end
        else if (enc_low)
        begin
            enc_code = grsc_pkg::CODE_LOW_CLAMP;
        end
        else
        begin
            enc_code = {enc_gain, enc_window[grsc_pkg::MANT_W-1:0]};
        end
    end

    // Result select: unused fields read as zero
    always_comb
    begin
        s2_result_next = '0;
        if (direction_reg == grsc_pkg::DIR_ENCODE)
        begin
            s2_result_next.code      = enc_code;
            s2_result_next.saturated = enc_high || enc_low;
        end
        else
        begin
            s2_result_next.sample = dec_sample;
        end
    end

    // Result stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (!s2_valid_reg || out_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Result stage payload
    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            s2_result_reg <= s2_result_next;
        end
    end

    assign out_valid  = s2_valid_reg;
    assign sample_out = s2_result_reg.sample;
    assign code_out   = s2_result_reg.code;
    assign saturated  = s2_result_reg.saturated;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A saturated result always carries one of the clamp codes
    a_sat_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |->
            (code_out == grsc_pkg::CODE_HIGH_CLAMP || code_out == grsc_pkg::CODE_LOW_CLAMP))
        else $error("saturated result without clamp code");

    // Decode and encode fields are never both populated
    a_one_path: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && sample_out != '0) |-> (code_out == '0 && !saturated))
        else $error("decode and encode fields both nonzero");

    // An input transfer always lands in the input stage
    a_s1_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> s1_valid_reg)
        else $error("input transfer lost");

    // A held input stage item is not dropped while the result stage is stalled
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_valid_reg && !out_ready) |=> (s1_valid_reg && s2_valid_reg))
        else $error("item dropped under output stall");

endmodule

/* tb/codec_checker.sv */
// ============================================================================
// codec_checker: result predictor and comparator for the sample codec
// Follows direction writes, predicts one result for every input transfer and
// compares each output transfer field by field against the oldest prediction.
// ============================================================================
module codec_checker (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      cfg_wr_en,
    input  logic                                      cfg_wr_data,
    input  logic                                      in_valid,
    input  logic                                      in_ready,
    input  logic [grsc_pkg::CODE_W-1:0]               code_in,
    input  logic signed [grsc_pkg::SAMPLE_IN_W-1:0]   sample_in,
    input  logic                                      out_valid,
    input  logic                                      out_ready,
    input  logic signed [grsc_pkg::SAMPLE_OUT_W-1:0]  sample_out,
    input  logic [grsc_pkg::CODE_W-1:0]               code_out,
    input  logic                                      saturated,
    output int                                        mismatch_count,
    output int                                        outstanding
);

    grsc_pkg::grsc_result_t pending_results [$];
    logic                   direction;

    // Expected conversion of one input item under the given direction
    function automatic grsc_pkg::grsc_result_t convert_item(
        input logic                                    dir,
        input logic [grsc_pkg::CODE_W-1:0]             code,
        input logic signed [grsc_pkg::SAMPLE_IN_W-1:0] x);
        grsc_pkg::grsc_result_t                   res;
        logic [grsc_pkg::GAIN_W-1:0]              gain;
        logic signed [grsc_pkg::MANT_W-1:0]       mant;
        logic signed [grsc_pkg::SAMPLE_OUT_W-1:0] wide;
        logic signed [grsc_pkg::SAMPLE_IN_W-1:0]  probe;
        logic signed [grsc_pkg::SAMPLE_IN_W-1:0]  window;
        res = '0;
        if (dir == grsc_pkg::DIR_DECODE)
        begin
            gain = code[grsc_pkg::CODE_W-1 -: grsc_pkg::GAIN_W];
            mant = code[grsc_pkg::MANT_W-1:0];
            wide = mant;    // sign extend
            res.sample = wide <<< (int'(grsc_pkg::MAX_SHIFT) - 2 * int'(gain));
        end
        else if (x > grsc_pkg::ENC_HIGH_LIMIT)
        begin
            res.code      = grsc_pkg::CODE_HIGH_CLAMP;
            res.saturated = 1'b1;
        end
        else if (x < grsc_pkg::ENC_LOW_LIMIT)
        begin
            res.code      = grsc_pkg::CODE_LOW_CLAMP;
            res.saturated = 1'b1;
        end
        else
        begin
            // largest gain whose upper bits are pure sign wins
            gain = '0;
            for (int k = 1; k <= 7; k++)
            begin
                probe = x >>> (26 - 2 * k);
                if (probe == 0 || probe == -1)
                    gain = grsc_pkg::GAIN_W'(k);
            end
            window   = x >>> (int'(grsc_pkg::MAX_SHIFT) - 2 * int'(gain));
            res.code = {gain, window[grsc_pkg::MANT_W-1:0]};
        end
        return res;
    endfunction

    // Predict on input transfers, track direction, check output transfers
    always @(posedge clk or negedge rst_n)
    begin
        grsc_pkg::grsc_result_t want;
        if (!rst_n)
        begin
            pending_results.delete();
            direction      = grsc_pkg::DIR_DECODE;
            mismatch_count = 0;
            outstanding    = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                pending_results.push_back(convert_item(direction, code_in, sample_in));
            if (cfg_wr_en)
                direction = cfg_wr_data;
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual %0d/%h/%b",
                             $time, sample_out, code_out, saturated);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (sample_out !== want.sample)
                    begin
                        $display("%0t: sample_out mismatch: expected %0d actual %0d",
                                 $time, want.sample, sample_out);
                        mismatch_count++;
                    end
                    if (code_out !== want.code)
                    begin
                        $display("%0t: code_out mismatch: expected %h actual %h",
                                 $time, want.code, code_out);
                        mismatch_count++;
                    end
                    if (saturated !== want.saturated)
                    begin
                        $display("%0t: saturated mismatch: expected %b actual %b",
                                 $time, want.saturated, saturated);
                        mismatch_count++;
                    end
                end
            end
            outstanding = pending_results.size();
        end
    end

endmodule

/* tb/tb_top.sv */
// ============================================================================
// tb_top: stimulus and verdict for the gain-ranged sample codec
// Writes the direction register between drained phases, sends corner codes
// and samples, then random items under three idle/stall mixes.
// ============================================================================
module tb_top;

    localparam int CYCLE_LIMIT   = 100000;
    localparam int ITEMS_PER_RUN = 125;

    logic                                      clk = 1'b0;
    logic                                      rst_n;
    logic                                      cfg_wr_en;
    logic                                      cfg_wr_data;
    logic                                      in_valid;
    logic                                      in_ready;
    logic [grsc_pkg::CODE_W-1:0]               code_in;
    logic signed [grsc_pkg::SAMPLE_IN_W-1:0]   sample_in;
    logic                                      out_valid;
    logic                                      out_ready;
    logic signed [grsc_pkg::SAMPLE_OUT_W-1:0]  sample_out;
    logic [grsc_pkg::CODE_W-1:0]               code_out;
    logic                                      saturated;

    int mismatch_count;
    int outstanding;
    int cycle_count = 0;
    int sender_idle_pct;
    int receiver_stall_pct;

    // Decode corners: gain extremes, mantissa extremes, alternating bits
    logic [grsc_pkg::CODE_W-1:0] code_corners [11] = '{
        16'h0000, 16'h1000, 16'h0fff, 16'h1fff, 16'he000, 16'hefff,
        16'hf000, 16'hffff, 16'h2001, 16'h5555, 16'haaaa
    };

    // Encode corners: clamp limits, full-scale, zero, gain boundaries
    logic signed [grsc_pkg::SAMPLE_IN_W-1:0] sample_corners [14] = '{
        28'sd67108856, 28'sd67108857, 28'sd134217727, -28'sd67108864,
        -28'sd67108865, -28'sd134217728, 28'sd0, -28'sd1, 28'sd4095,
        28'sd4096, -28'sd4096, -28'sd4097, 28'sd16777215, -28'sd16777217
    };

    gain_ranged_sample_codec dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .code_in     (code_in),
        .sample_in   (sample_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .sample_out  (sample_out),
        .code_out    (code_out),
        .saturated   (saturated)
    );

    codec_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .code_in        (code_in),
        .sample_in      (sample_in),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sample_out     (sample_out),
        .code_out       (code_out),
        .saturated      (saturated),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    always #5 clk = ~clk;

    // Receiver stalls at random
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout", $time);
            $display("tb_top: errors");
            $finish;
        end
    end

    // One input transfer; called and returns at a falling edge
    task automatic send_item(input logic [grsc_pkg::CODE_W-1:0] code,
                             input logic signed [grsc_pkg::SAMPLE_IN_W-1:0] sample);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        code_in   <= code;
        sample_in <= sample;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // Drain all results, then write the direction register
    task automatic write_direction(input logic dir);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= dir;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Random items for one direction
    task automatic send_random(input logic dir, input int count);
        logic signed [grsc_pkg::SAMPLE_IN_W-1:0] x;
        write_direction(dir);
        repeat (count)
        begin
            case ($urandom_range(3))
                0: x = $signed(grsc_pkg::SAMPLE_IN_W'($urandom));
                1, 2: x = $signed(grsc_pkg::SAMPLE_IN_W'($urandom)) >>> $urandom_range(27);
                default:
                    if ($urandom_range(1))
                        x = grsc_pkg::SAMPLE_IN_W'(grsc_pkg::ENC_HIGH_LIMIT +
                                                   int'($urandom_range(8)) - 4);
                    else
                        x = grsc_pkg::SAMPLE_IN_W'(grsc_pkg::ENC_LOW_LIMIT +
                                                   int'($urandom_range(8)) - 4);
            endcase
            send_item(grsc_pkg::CODE_W'($urandom), x);
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = 1'b0;
        in_valid           = 1'b0;
        code_in            = '0;
        sample_in          = '0;
        sender_idle_pct    = 7;
        receiver_stall_pct = 49;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed corners in both directions
        write_direction(grsc_pkg::DIR_DECODE);
        foreach (code_corners[i])
            send_item(code_corners[i], $signed(grsc_pkg::SAMPLE_IN_W'($urandom)));
        write_direction(grsc_pkg::DIR_ENCODE);
        foreach (sample_corners[i])
            send_item(grsc_pkg::CODE_W'($urandom), sample_corners[i]);

        // random items under three idle/stall mixes
        for (int phase = 0; phase < 3; phase++)
        begin
            sender_idle_pct    = (phase == 0) ? 7 : (phase == 1) ? 49 : 0;
            receiver_stall_pct = (phase == 0) ? 49 : (phase == 1) ? 7 : 0;
            send_random(grsc_pkg::DIR_DECODE, ITEMS_PER_RUN);
            send_random(grsc_pkg::DIR_ENCODE, ITEMS_PER_RUN);
        end

        // drain and settle
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);

        if (mismatch_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
